// ----- src/gmsp_pkg.sv -----
// Shared constants for the grid minimum-spread path search block.
// Used by grid_min_spread_path_top; depends on nothing.
`timescale 1ns / 1ps

package gmsp_pkg;

    localparam int MAX_SIDE_DEF   = 128;
    localparam int VALUE_BITS_DEF = 8;

    // Configuration register map (register index in paddr bit 2)
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_IDX_SIDE = 1'b0;

    // Neighbor directions, walked in this order
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_UP    = 2'd0;
    localparam t_dir DIR_DOWN  = 2'd1;
    localparam t_dir DIR_LEFT  = 2'd2;
    localparam t_dir DIR_RIGHT = 2'd3;

endpackage

// ----- src/grid_min_spread_path_top.sv -----
// Top level of the grid minimum-spread path search block.
// Depends on gmsp_pkg for constants and direction codes.
`timescale 1ns / 1ps

// Loads a square grid (side set by register grid_side at address 0) one cell
// per cycle in raster order, tracking the least and greatest value. The cell
// flagged last_cell starts a search: a binary search on the spread w, and for
// each w a scan of bands [b, b+w]; each band runs a breadth-first flood from
// the top-left to the bottom-right corner over cells inside the band. The
// least passing w comes out on min_spread. Requests on the input are taken
// one per cycle while loading; during a search the input stalls. Each band
// is picked, then its two corners are read and checked; a flood then clears
// the visited map cell by cell, seeds the queue, pops each reached cell and
// probes its in-bounds neighbors, skipping out-of-bounds directions, until it
// finds the queue empty or reaches the bottom-right corner, all bound by the
// single read port of the grid and visited memories.
// A search runs up to about VALUE_BITS binary steps, each with up to
// 2^VALUE_BITS bands. The result sits in an output register, so the next
// grid may start loading while the result waits.
module grid_min_spread_path_top #(
    parameter int MAX_SIDE   = gmsp_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = gmsp_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gmsp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gmsp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gmsp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // input requests
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_cell_value,
    input  logic                            i_last_cell,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_min_spread
);
    import gmsp_pkg::*;

    localparam int SB    = $clog2(MAX_SIDE + 1);
    localparam int RB    = $clog2(MAX_SIDE);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IB    = $clog2(CELLS);
    localparam int CB    = IB + 1;
    localparam int VB    = VALUE_BITS;
    localparam int QW    = IB + 2 * RB;
    localparam int CW    = (SB > 8) ? SB : 8;

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_BSTEP, S_BAND, S_RD0, S_RDL, S_CHKL, S_CLEAR,
        S_SEED, S_POP, S_POPW, S_NISS, S_NCHK, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0]    r_grid_side;
    logic [SB-1:0] r_side;
    logic [CB-1:0] r_area;
    logic          w_cfg_wr;
    logic [CW-1:0] w_wr_side;
    logic [SB-1:0] w_side_clamp;

    // load state
    logic [CB-1:0] r_load_cnt;
    logic [VB-1:0] r_least, r_great;
    logic [15:0]   w_val_ext;
    logic [VB-1:0] w_val;
    logic          w_in_acc;

    // search state
    logic signed [VB+1:0] r_lower, r_upper;
    logic signed [VB+1:0] w_mid_sum;
    logic [VB-1:0] r_mid;
    logic [VB:0]   r_band;
    logic [VB:0]   w_band_hi;
    logic [IB-1:0] r_last;
    logic [CB-1:0] r_head, r_tail;
    logic [IB-1:0] r_cur_idx, r_nidx;
    logic [RB-1:0] r_cur_row, r_cur_col, r_nrow, r_ncol;
    t_dir          r_dir;
    logic [RB-1:0] w_side_m1;

    // neighbor generation
    logic          w_nok;
    logic [IB-1:0] w_nidx;
    logic [RB-1:0] w_nrow, w_ncol;

    // output
    logic          r_out_valid;
    logic [7:0]    r_min_spread;
    logic [VB+9:0] w_upper_ext;

    // memories
    logic [VB-1:0] m_grid [CELLS];
    logic          m_visit [CELLS];
    logic [QW-1:0] m_queue [CELLS];
    logic          w_g_we, w_v_we, w_v_wd, w_q_we;
    logic [IB-1:0] w_g_ra, w_v_wa, w_q_wa, w_q_ra;
    logic [QW-1:0] w_q_wd;
    logic [VB-1:0] r_gdata;
    logic          r_vdata;
    logic [QW-1:0] r_qdata;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign prdata   = CFG_DATA_W'(r_grid_side);
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_SIDE);
    assign w_wr_side = CW'(pwdata[7:0]);

    always_comb begin
        if (w_wr_side == '0) begin
            w_side_clamp = SB'(1);
        end else if (w_wr_side > CW'(MAX_SIDE)) begin
            w_side_clamp = SB'(MAX_SIDE);
        end else begin
            w_side_clamp = SB'(w_wr_side);
        end
    end

    // ---------------- datapath helpers ----------------
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_LOAD);
    assign w_val_ext  = {8'd0, i_cell_value};
    assign w_val      = w_val_ext[VB-1:0];
    assign w_band_hi  = r_band + (VB+1)'(r_mid);
    assign w_mid_sum  = r_upper + r_lower;
    assign w_side_m1  = RB'(r_side - SB'(1));
    assign w_upper_ext = {8'd0, r_upper};

    function automatic logic in_band(input logic [VB-1:0] v, input logic [VB:0] lo,
                                     input logic [VB:0] hi);
        in_band = ({1'b0, v} >= lo) && ({1'b0, v} <= hi);
    endfunction

    // Pick the neighbor for the current direction and check its bounds
    always_comb begin
        w_nok  = 1'b0;
        w_nidx = r_cur_idx;
        w_nrow = r_cur_row;
        w_ncol = r_cur_col;
        case (r_dir)
            DIR_UP: begin
                w_nok  = (r_cur_row != '0);
                w_nidx = r_cur_idx - IB'(r_side);
                w_nrow = r_cur_row - RB'(1);
            end
            DIR_DOWN: begin
                w_nok  = (r_cur_row != w_side_m1);
                w_nidx = r_cur_idx + IB'(r_side);
                w_nrow = r_cur_row + RB'(1);
            end
            DIR_LEFT: begin
                w_nok  = (r_cur_col != '0);
                w_nidx = r_cur_idx - IB'(1);
                w_ncol = r_cur_col - RB'(1);
            end
            default: begin
                w_nok  = (r_cur_col != w_side_m1);
                w_nidx = r_cur_idx + IB'(1);
                w_ncol = r_cur_col + RB'(1);
            end
        endcase
    end

    // ---------------- memory port control ----------------
    always_comb begin
        w_g_we = w_in_acc && (r_load_cnt < r_area);
        w_g_ra = w_nidx;
        if (r_state == S_RD0) begin
            w_g_ra = '0;
        end else if (r_state == S_RDL) begin
            w_g_ra = r_last;
        end

        w_v_we = 1'b0;
        w_v_wa = r_nidx;
        w_v_wd = 1'b1;
        w_q_we = 1'b0;
        w_q_wa = r_tail[IB-1:0];
        w_q_wd = {r_nidx, r_nrow, r_ncol};
        w_q_ra = r_head[IB-1:0];
        case (r_state)
            S_CLEAR: begin
                w_v_we = 1'b1;
                w_v_wa = r_head[IB-1:0];
                w_v_wd = 1'b0;
            end
            S_SEED: begin
                w_v_we = 1'b1;
                w_v_wa = '0;
                w_q_we = 1'b1;
                w_q_wa = '0;
                w_q_wd = '0;
            end
            S_NCHK: begin
                if (!r_vdata && in_band(r_gdata, r_band, w_band_hi) && (r_nidx != r_last)) begin
                    w_v_we = 1'b1;
                    w_q_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_g_we) begin
            m_grid[r_load_cnt[IB-1:0]] <= w_val;
        end
        r_gdata <= m_grid[w_g_ra];
        if (w_v_we) begin
            m_visit[w_v_wa] <= w_v_wd;
        end
        r_vdata <= m_visit[w_nidx];
        if (w_q_we) begin
            m_queue[w_q_wa] <= w_q_wd;
        end
        r_qdata <= m_queue[w_q_ra];
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_grid_side  <= 8'd1;
            r_side       <= SB'(1);
            r_area       <= CB'(1);
            r_load_cnt   <= '0;
            r_least      <= '1;
            r_great      <= '0;
            r_lower      <= '1;
            r_upper      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_grid_side <= pwdata[7:0];
                r_side      <= w_side_clamp;
                r_area      <= CB'(w_side_clamp * w_side_clamp);
            end
            // drop the result once taken; a finishing search reloads it below
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_load_cnt < r_area) begin
                            r_load_cnt <= r_load_cnt + CB'(1);
                            if (w_val < r_least) r_least <= w_val;
                            if (w_val > r_great) r_great <= w_val;
                        end
                        if (i_last_cell) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_lower <= '1;
                    r_upper <= (r_great > r_least) ? (VB+2)'(r_great - r_least) : '0;
                    r_last  <= IB'(r_area - CB'(1));
                    r_state <= S_BSTEP;
                end
                S_BSTEP: begin
                    if (r_upper > r_lower + (VB+2)'(1)) begin
                        r_mid   <= VB'(w_mid_sum >>> 1);
                        r_band  <= {1'b0, r_least};
                        r_state <= S_BAND;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_BAND: begin
                    if (w_band_hi <= {1'b0, r_great}) begin
                        r_state <= S_RD0;
                    end else begin
                        r_lower <= (VB+2)'(r_mid);
                        r_state <= S_BSTEP;
                    end
                end
                S_RD0: begin
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    // grid[0] arrives here
                    if (in_band(r_gdata, r_band, w_band_hi)) begin
                        r_state <= S_CHKL;
                    end else begin
                        r_band  <= r_band + (VB+1)'(1);
                        r_state <= S_BAND;
                    end
                end
                S_CHKL: begin
                    if (!in_band(r_gdata, r_band, w_band_hi)) begin
                        r_band  <= r_band + (VB+1)'(1);
                        r_state <= S_BAND;
                    end else if (r_last == '0) begin
                        r_upper <= (VB+2)'(r_mid);
                        r_state <= S_BSTEP;
                    end else begin
                        r_head  <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    // sweep the visited map, one cell a cycle
                    r_head <= r_head + CB'(1);
                    if (r_head[IB-1:0] == r_last) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_head  <= '0;
                    r_tail  <= CB'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_head == r_tail) begin
                        r_band  <= r_band + (VB+1)'(1);
                        r_state <= S_BAND;
                    end else begin
                        r_head  <= r_head + CB'(1);
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    {r_cur_idx, r_cur_row, r_cur_col} <= r_qdata;
                    r_dir   <= DIR_UP;
                    r_state <= S_NISS;
                end
                S_NISS: begin
                    if (w_nok) begin
                        r_nidx  <= w_nidx;
                        r_nrow  <= w_nrow;
                        r_ncol  <= w_ncol;
                        r_state <= S_NCHK;
                    end else if (r_dir == DIR_RIGHT) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir <= r_dir + t_dir'(1);
                    end
                end
                S_NCHK: begin
                    if (!r_vdata && in_band(r_gdata, r_band, w_band_hi)
                        && (r_nidx == r_last)) begin
                        r_upper <= (VB+2)'(r_mid);
                        r_state <= S_BSTEP;
                    end else begin
                        if (w_q_we) begin
                            r_tail <= r_tail + CB'(1);
                        end
                        if (r_dir == DIR_RIGHT) begin
                            r_state <= S_POP;
                        end else begin
                            r_dir   <= r_dir + t_dir'(1);
                            r_state <= S_NISS;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_min_spread <= w_upper_ext[7:0];
                        r_load_cnt   <= '0;
                        r_least      <= '1;
                        r_great      <= '0;
                        r_state      <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_min_spread = r_min_spread;

endmodule

// ----- dv/grid_min_spread_path_top_tb.sv -----
// Testbench for grid_min_spread_path_top: loads square grids, predicts the least
// corner-to-corner spread in place and checks every result. Depends on gmsp_pkg.
`timescale 1ns / 1ps

module grid_min_spread_path_top_tb;
    import gmsp_pkg::*;

    localparam int SIDE_CAP      = 128;
    localparam int CELL_TOTAL    = SIDE_CAP * SIDE_CAP;
    localparam int RANDOM_ITEMS  = 850;
    localparam int STALL_LIMIT   = 4000000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } cell_req_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_cell_value = '0;
    logic                  i_last_cell = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_min_spread;

    grid_min_spread_path_top i_dut (.*);

    // Hold high 5 ns, low 5 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending requests, expected spreads and run bookkeeping.
    cell_req_t   cell_q[$];
    logic [7:0]  spread_q[$];
    int          send_idle_pct = 0;
    int          take_stall_pct = 0;
    int          mismatches = 0;
    longint      handshakes = 0;

    // Predictor state: a mirror of the grid memory and the load trackers.
    logic [7:0]  grid_mem [CELL_TOTAL];
    bit          seen_map [CELL_TOTAL];
    int          bfs_q    [CELL_TOTAL];
    logic [7:0]  side_reg = 8'd1;
    int          loaded = 0;
    int          lowest = 255;
    int          highest = 0;

    // Generator bookkeeping: how far the memory has ever been written.
    int          gen_written = 0;
    int          gen_loaded = 0;
    int          gen_count = 0;

    function automatic int clamp_side(logic [7:0] s);
        if (s == 0) return 1;
        if (s > SIDE_CAP) return SIDE_CAP;
        return int'(s);
    endfunction

    // Flood from the top-left corner through cells inside [lo, hi].
    function automatic bit corner_path(int side, int lo, int hi);
        int last_idx, head, tail, cur, r, c, nr, nc, idx, d;
        int dr [4];
        int dc [4];
        dr = '{-1, 1, 0, 0};
        dc = '{0, 0, -1, 1};
        last_idx = side * side - 1;
        if (grid_mem[0] < lo || grid_mem[0] > hi) return 1'b0;
        if (grid_mem[last_idx] < lo || grid_mem[last_idx] > hi) return 1'b0;
        if (last_idx == 0) return 1'b1;
        for (int k = 0; k <= last_idx; k++) seen_map[k] = 1'b0;
        head = 0;
        tail = 1;
        bfs_q[0] = 0;
        seen_map[0] = 1'b1;
        while (head < tail) begin
            cur = bfs_q[head];
            head++;
            r = cur / side;
            c = cur % side;
            for (d = 0; d < 4; d++) begin
                nr = r + dr[d];
                nc = c + dc[d];
                if (nr < 0 || nc < 0 || nr >= side || nc >= side) continue;
                idx = nr * side + nc;
                if (seen_map[idx] || grid_mem[idx] < lo || grid_mem[idx] > hi) continue;
                if (idx == last_idx) return 1'b1;
                seen_map[idx] = 1'b1;
                bfs_q[tail] = idx;
                tail++;
            end
        end
        return 1'b0;
    endfunction

    // Binary search on the band width; the lower bound starts below zero.
    function automatic logic [7:0] least_spread(int side);
        int lower, upper, mid;
        bit found;
        lower = -1;
        upper = (highest > lowest) ? highest - lowest : 0;
        while (upper > lower + 1) begin
            mid = (upper + lower) / 2;
            found = 1'b0;
            for (int b = lowest; b + mid <= highest && !found; b++)
                found = corner_path(side, b, b + mid);
            if (found) upper = mid;
            else lower = mid;
        end
        return upper[7:0];
    endfunction

    // Apply one accepted request to the mirror; queue a spread on the last cell.
    task automatic absorb_cell(cell_req_t req);
        int side;
        side = clamp_side(side_reg);
        if (loaded < side * side) begin
            grid_mem[loaded] = req.value;
            if (req.value < lowest) lowest = req.value;
            if (req.value > highest) highest = req.value;
            loaded++;
        end
        if (req.last) begin
            spread_q.push_back(least_spread(side));
            loaded = 0;
            lowest = 255;
            highest = 0;
        end
    endtask

    // Driver: advance to the next request on acceptance, hold while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                absorb_cell('{value: i_cell_value, last: i_last_cell});
                handshakes++;
            end
            if (cell_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cell_req_t nxt;
                nxt = cell_q.pop_front();
                i_in_valid   <= 1'b1;
                i_cell_value <= nxt.value;
                i_last_cell  <= nxt.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted spread with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                handshakes++;
                if (spread_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected spread %0d at %0t", o_min_spread, $realtime);
                end else begin
                    logic [7:0] want;
                    want = spread_q.pop_front();
                    if (want !== o_min_spread) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("min_spread mismatch: expected %0d, got %0d at %0t",
                                     want, o_min_spread, $realtime);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < take_stall_pct);
        end
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge i_clk) begin
        longint last_seen;
        int quiet;
        if (handshakes != last_seen || !i_rst_n) begin
            quiet = 0;
            last_seen = handshakes;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Queue one cell, tracking how far the grid memory has been written.
    task automatic push_cell(int side, int value, bit last);
        if (gen_loaded < side * side) begin
            if (gen_loaded >= gen_written) gen_written = gen_loaded + 1;
            gen_loaded++;
        end
        if (last) gen_loaded = 0;
        gen_count++;
        cell_q.push_back('{value: value[7:0], last: last});
    endtask

    // Wait until every request went out and every spread came back.
    task automatic drain();
        do @(posedge i_clk);
        while (cell_q.size() != 0 || i_in_valid || spread_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write with a setup phase and an access phase; the write lands when pready is high.
    task automatic write_side(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_IDX_SIDE) << 2;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        side_reg = value[7:0];
    endtask

    // Queue one grid: full, short (only over written cells) or with extra cells.
    task automatic queue_grid(int side, int base, int span, int shape);
        int cells;
        cells = side * side;
        if (shape == 1 && gen_written >= cells && cells > 1)
            cells = $urandom_range(1, cells - 1);
        else if (shape == 2)
            cells = cells + $urandom_range(1, 3);
        for (int k = 0; k < cells; k++) begin
            int v;
            v = base + $urandom_range(0, span);
            if (v > 255) v = 255;
            push_cell(side, v, k == cells - 1);
        end
    endtask

    initial begin
        int side;
        int span;
        int mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Side of one after reset: answer is zero for any value.
        push_cell(1, 0, 1'b1);
        push_cell(1, 255, 1'b1);
        drain();
        write_side(2);
        push_cell(2, 0, 1'b0);
        push_cell(2, 255, 1'b0);
        push_cell(2, 255, 1'b0);
        push_cell(2, 0, 1'b1);
        // Extra cells beyond side*side are dropped.
        push_cell(2, 255, 1'b0);
        push_cell(2, 170, 1'b0);
        push_cell(2, 85, 1'b0);
        push_cell(2, 255, 1'b0);
        push_cell(2, 0, 1'b0);
        push_cell(2, 85, 1'b1);
        // Short grid: one new cell, the rest from the last grid.
        push_cell(2, 128, 1'b1);
        drain();
        write_side(0);
        push_cell(1, 77, 1'b1);
        drain();
        // Side changed while loading: placement uses the side at search time.
        write_side(3);
        push_cell(3, 10, 1'b0);
        push_cell(3, 200, 1'b0);
        drain();
        write_side(2);
        push_cell(2, 40, 1'b0);
        push_cell(2, 15, 1'b1);
        drain();

        // Random grids, rotating through the flow-control phases.
        gen_count = 0;
        mode = 0;
        while (gen_count < RANDOM_ITEMS) begin
            drain();
            case (mode % 5)
                0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1: begin send_idle_pct = 83; take_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  take_stall_pct = 83; end
                3: begin send_idle_pct = 8;  take_stall_pct = 8;  end
                default: begin send_idle_pct = 0; take_stall_pct = 0; end
            endcase
            mode++;
            side = $urandom_range(0, 8);
            write_side(side);
            side = clamp_side(side[7:0]);
            repeat (5) begin
                if (side <= 2 && $urandom_range(3) == 0) span = 255;
                else if ($urandom_range(3) == 0) span = $urandom_range(0, 31);
                else span = $urandom_range(0, 4);
                queue_grid(side, (span == 255) ? 0 : $urandom_range(0, 255), span,
                           $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2));
            end
        end
        drain();

        if (mismatches == 0 && spread_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
